### sv/ssm_pkg.sv
// shared types, codes and sizes of the sparse span merge block
package ssm_pkg;

  localparam int unsigned Depth     = 4096;
  localparam int unsigned AW        = $clog2(Depth);
  localparam int unsigned CW        = AW + 1;
  localparam int unsigned FifoDepth = 2;

  // command codes on the input channel
  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_SCAN  = 3'd1;
  localparam logic [2:0] CMD_PLACE = 3'd2;
  localparam logic [2:0] CMD_BYTE  = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;
  localparam logic [2:0] CMD_RUN   = 3'd5;

  // status codes
  localparam logic [2:0] STAT_NONE      = 3'd0;
  localparam logic [2:0] STAT_SUCCESS   = 3'd1;
  localparam logic [2:0] STAT_PARTIAL   = 3'd2;
  localparam logic [2:0] STAT_ERROR     = 3'd3;
  localparam logic [2:0] STAT_TOO_LARGE = 3'd4;

  // timing codes
  localparam logic [1:0] TIME_SINGLE   = 2'd0;
  localparam logic [1:0] TIME_MULTIPLE = 2'd1;
  localparam logic [1:0] TIME_UNKNOWN  = 2'd2;

  // message codes
  localparam logic [1:0] MSG_NONE       = 2'd0;
  localparam logic [1:0] MSG_CONFLICT   = 2'd1;
  localparam logic [1:0] MSG_DIFF_TIMES = 2'd2;
  localparam logic [1:0] MSG_NO_TIME    = 2'd3;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_SCAN   = 3'd1,
    OP_PLACE  = 3'd2,
    OP_BYTE   = 3'd3,
    OP_READ   = 3'd4,
    OP_RUN    = 3'd5,
    OP_STATUS = 3'd6
  } op_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] span_begin;
    logic [63:0] span_length;
    logic        time_present;
    logic [63:0] time_value;
    logic [7:0]  byte_value;
    logic        byte_present;
    logic [11:0] read_offset;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  timing;
    logic [1:0]  message;
    logic [63:0] window_begin;
    logic [12:0] window_length;
    logic [7:0]  read_value;
    logic        read_present;
    logic        run_valid;
    logic [63:0] run_begin;
    logic [12:0] run_length;
  } out_beat_t;

  // classified command as it waits in the queue
  typedef struct packed {
    op_e         op;
    logic        admitted;
    logic [63:0] span_begin;
    logic [63:0] span_end;
    logic        time_present;
    logic [63:0] time_value;
    logic [7:0]  byte_value;
    logic        byte_present;
    logic [11:0] read_offset;
  } item_t;

endpackage

### sv/ssm_if.sv
// valid/ready channel interfaces for input and result beats
interface ssm_in_if;
  logic              valid;
  logic              ready;
  ssm_pkg::in_beat_t beat;
  modport source (output valid, output beat, input ready);
  modport sink (input valid, input beat, output ready);
endinterface

interface ssm_out_if;
  logic               valid;
  logic               ready;
  ssm_pkg::out_beat_t beat;
  modport source (output valid, output beat, input ready);
  modport sink (input valid, input beat, output ready);
endinterface

### sv/sparse_span_merge.sv
// top level of the sparse span merge block
//
// in_i carries one command beat (clear, scan header, place header, span byte,
// read byte, next conflict run, status query for any other code); out_o returns
// exactly one result beat per command, in order, with merged status, timing,
// message and window. the front decodes each beat and checks span admission
// (64-bit end sum), then drops it into a two-entry queue; the back executes one
// command at a time against the 4096 x 10 bit window store (byte, present, conflict).
// in the back, status query and place header go straight to the result; scan
// header then sizes the window from the bounds (skipped when not admitted); span
// byte and read byte do one registered store read, then the write or answer (no
// read when the byte is dropped or the offset is outside the window); clear
// writes one store entry per cycle; next conflict run does one store read per
// entry walked until the run ends or the walk reaches the window end.
// a busy back holds a new command in the queue until its current one is done.
// after reset the back sweeps the whole store and in_i.ready stays low until
// the sweep is done.
// when out_o is stalled the result waits in the output register, the back
// holds its next finished result and the queue keeps taking beats until full.
module sparse_span_merge (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssm_in_if.sink    in_i,
  ssm_out_if.source out_o
);

  logic           push, full, pop, q_valid, init_busy;
  ssm_pkg::item_t push_item, head_item;

  // decode and admission check
  ssm_front u_front (
    .in_i        (in_i),
    .full_i      (full),
    .init_busy_i (init_busy),
    .push_o      (push),
    .item_o      (push_item)
  );

  // decoupling queue
  ssm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  // execution, store and result register
  ssm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (head_item),
    .pop_o       (pop),
    .init_busy_o (init_busy),
    .out_o       (out_o)
  );

endmodule

### sv/ssm_front.sv
// front end: accepts input beats, decodes the command and checks span admission
module ssm_front (
  ssm_in_if.sink        in_i,
  input  logic          full_i,
  input  logic          init_busy_i,
  output logic          push_o,
  output ssm_pkg::item_t item_o
);

  logic [64:0] sum;

  assign in_i.ready = !full_i && !init_busy_i;
  assign push_o     = in_i.valid && in_i.ready;
  assign sum        = {1'b0, in_i.beat.span_begin} + {1'b0, in_i.beat.span_length};

  always_comb begin
    item_o.admitted     = (in_i.beat.span_length != 64'd0) && !sum[64];
    item_o.span_begin   = in_i.beat.span_begin;
    item_o.span_end     = sum[63:0];
    item_o.time_present = in_i.beat.time_present;
    item_o.time_value   = in_i.beat.time_value;
    item_o.byte_value   = in_i.beat.byte_value;
    item_o.byte_present = in_i.beat.byte_present;
    item_o.read_offset  = in_i.beat.read_offset;
    unique case (in_i.beat.cmd)
      ssm_pkg::CMD_CLEAR: item_o.op = ssm_pkg::OP_CLEAR;
      ssm_pkg::CMD_SCAN:  item_o.op = ssm_pkg::OP_SCAN;
      ssm_pkg::CMD_PLACE: item_o.op = ssm_pkg::OP_PLACE;
      ssm_pkg::CMD_BYTE:  item_o.op = ssm_pkg::OP_BYTE;
      ssm_pkg::CMD_READ:  item_o.op = ssm_pkg::OP_READ;
      ssm_pkg::CMD_RUN:   item_o.op = ssm_pkg::OP_RUN;
      default:            item_o.op = ssm_pkg::OP_STATUS;
    endcase
  end

endmodule

### sv/ssm_fifo.sv
// short queue of decoded commands between front and back
module ssm_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ssm_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ssm_pkg::item_t item_o
);

  localparam int unsigned PW = $clog2(ssm_pkg::FifoDepth);

  ssm_pkg::item_t mem_q [ssm_pkg::FifoDepth];
  logic [PW-1:0]  wr_q, rd_q;
  logic [PW:0]    cnt_q;

  assign full_o  = cnt_q == (PW+1)'(ssm_pkg::FifoDepth);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(ssm_pkg::FifoDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(ssm_pkg::FifoDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

### sv/ssm_back.sv
// back end: merge state, window store with present and conflict marks, result register
module ssm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  ssm_pkg::item_t item_i,
  output logic           pop_o,
  output logic           init_busy_o,
  ssm_out_if.source      out_o
);

  localparam int unsigned AW = ssm_pkg::AW;
  localparam int unsigned CW = ssm_pkg::CW;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN2 = 8'b0000_0010,
    S_BYTE  = 8'b0000_0100,
    S_READ  = 8'b0000_1000,
    S_RUNRD = 8'b0001_0000,
    S_RUNCK = 8'b0010_0000,
    S_RESP  = 8'b0100_0000,
    S_CLEAR = 8'b1000_0000
  } state_e;

  state_e         state_q, state_d;
  ssm_pkg::item_t cur_q, cur_d;

  logic [63:0] lowest_q, lowest_d, highest_q, highest_d;
  logic        any_q, any_d;
  logic [1:0]  acnt_q, acnt_d;
  logic        tmiss_q, tmiss_d, tdiff_q, tdiff_d, ftv_q, ftv_d;
  logic [63:0] ftime_q, ftime_d;
  logic        big_q, big_d;
  logic [CW-1:0] wl_q, wl_d;
  logic [CW-1:0] base_q, base_d, pidx_q, pidx_d;
  logic        pok_q, pok_d;
  logic [CW-1:0] pcnt_q, pcnt_d, ccnt_q, ccnt_d, cursor_q, cursor_d;
  logic [AW-1:0] baddr_q, baddr_d;
  logic [AW-1:0] clr_q, clr_d;
  logic        init_q, init_d, clrcmd_q, clrcmd_d;
  logic [CW-1:0] ri_q, ri_d, rs_q, rs_d;
  logic        phase_q, phase_d;
  logic [7:0]  rdv_q, rdv_d;
  logic        rdp_q, rdp_d, rv_q, rv_d;
  logic [63:0] rb_q, rb_d;
  logic [CW-1:0] rl_q, rl_d;

  logic        out_valid_q;
  ssm_pkg::out_beat_t out_q, res;
  logic        load;

  // store word: conflict, present, byte
  logic [9:0]    mem [ssm_pkg::Depth];
  logic [9:0]    rdata_q, wdata;
  logic          rd_en, we;
  logic [AW-1:0] raddr, waddr;

  logic [CW:0]   tsum;
  logic [63:0]   diff;
  logic [1:0]    timing;
  logic          conf_new;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  assign init_busy_o = init_q;
  assign out_o.valid = out_valid_q;
  assign out_o.beat  = out_q;
  assign tsum        = {1'b0, base_q} + {1'b0, pidx_q};
  assign diff        = highest_q - lowest_q;
  assign conf_new    = rdata_q[9] || (rdata_q[8] && (rdata_q[7:0] != cur_q.byte_value));

  // merged report from the current state
  always_comb begin
    if (tdiff_q) begin
      timing = ssm_pkg::TIME_MULTIPLE;
    end else if (acnt_q > 2'd1 && tmiss_q) begin
      timing = ssm_pkg::TIME_UNKNOWN;
    end else begin
      timing = ssm_pkg::TIME_SINGLE;
    end
    res               = '0;
    res.timing        = timing;
    res.window_begin  = any_q ? lowest_q : 64'd0;
    res.read_value    = rdv_q;
    res.read_present  = rdp_q;
    res.run_valid     = rv_q;
    res.run_begin     = rb_q;
    res.run_length    = 13'(rl_q);
    if (!any_q) begin
      res.status = ssm_pkg::STAT_NONE;
    end else if (big_q) begin
      res.status        = ssm_pkg::STAT_TOO_LARGE;
      res.window_length = 13'(ssm_pkg::Depth);
    end else begin
      res.window_length = 13'(wl_q);
      if (pcnt_q >= wl_q) begin
        res.status = (ccnt_q != '0 || timing != ssm_pkg::TIME_SINGLE) ?
                     ssm_pkg::STAT_PARTIAL : ssm_pkg::STAT_SUCCESS;
      end else if (pcnt_q == '0) begin
        res.status = ssm_pkg::STAT_ERROR;
      end else begin
        res.status = ssm_pkg::STAT_PARTIAL;
      end
      if (ccnt_q != '0) begin
        res.message = ssm_pkg::MSG_CONFLICT;
      end else if (timing == ssm_pkg::TIME_MULTIPLE) begin
        res.message = ssm_pkg::MSG_DIFF_TIMES;
      end else if (timing == ssm_pkg::TIME_UNKNOWN) begin
        res.message = ssm_pkg::MSG_NO_TIME;
      end
    end
  end

  always_comb begin
    state_d = state_q;   cur_d = cur_q;
    lowest_d = lowest_q; highest_d = highest_q; any_d = any_q; acnt_d = acnt_q;
    tmiss_d = tmiss_q;   tdiff_d = tdiff_q;     ftv_d = ftv_q; ftime_d = ftime_q;
    big_d = big_q;       wl_d = wl_q;
    base_d = base_q;     pidx_d = pidx_q;       pok_d = pok_q;
    pcnt_d = pcnt_q;     ccnt_d = ccnt_q;       cursor_d = cursor_q;
    baddr_d = baddr_q;   clr_d = clr_q;         init_d = init_q; clrcmd_d = clrcmd_q;
    ri_d = ri_q;         rs_d = rs_q;           phase_d = phase_q;
    rdv_d = rdv_q;       rdp_d = rdp_q;         rv_d = rv_q; rb_d = rb_q; rl_d = rl_q;
    pop_o = 1'b0;        load = 1'b0;
    rd_en = 1'b0;        raddr = '0;
    we = 1'b0;           waddr = '0;            wdata = '0;

    unique case (state_q)
      S_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          cur_d = item_i;
          rdv_d = '0; rdp_d = 1'b0; rv_d = 1'b0; rb_d = '0; rl_d = '0;
          state_d = S_RESP;
          unique case (item_i.op)
            ssm_pkg::OP_CLEAR: begin
              lowest_d = '0; highest_d = '0; any_d = 1'b0; acnt_d = '0;
              tmiss_d = 1'b0; tdiff_d = 1'b0; ftv_d = 1'b0; ftime_d = '0;
              big_d = 1'b0; wl_d = '0; base_d = '0; pidx_d = '0; pok_d = 1'b0;
              pcnt_d = '0; ccnt_d = '0; cursor_d = '0;
              clr_d = '0; clrcmd_d = 1'b1;
              state_d = S_CLEAR;
            end
            ssm_pkg::OP_SCAN: begin
              if (item_i.admitted) begin
                if (acnt_q != 2'd2) begin
                  acnt_d = acnt_q + 2'd1;
                end
                if (!item_i.time_present) begin
                  tmiss_d = 1'b1;
                end else if (!ftv_q) begin
                  ftv_d = 1'b1;
                  ftime_d = item_i.time_value;
                end else if (ftime_q != item_i.time_value) begin
                  tdiff_d = 1'b1;
                end
                any_d = 1'b1;
                if (!any_q || item_i.span_begin < lowest_q) begin
                  lowest_d = item_i.span_begin;
                end
                if (!any_q || item_i.span_end > highest_q) begin
                  highest_d = item_i.span_end;
                end
                state_d = S_SCAN2;
              end
            end
            ssm_pkg::OP_PLACE: begin
              pok_d = 1'b0; pidx_d = '0; base_d = '0;
              if (item_i.admitted && wl_q != '0 && item_i.span_begin >= lowest_q &&
                  item_i.span_end <= highest_q) begin
                base_d = CW'(item_i.span_begin - lowest_q);
                pok_d = 1'b1;
              end
            end
            ssm_pkg::OP_BYTE: begin
              if (pok_q) begin
                if (tsum < {1'b0, wl_q} && item_i.byte_present) begin
                  rd_en = 1'b1;
                  raddr = tsum[AW-1:0];
                  baddr_d = tsum[AW-1:0];
                  state_d = S_BYTE;
                end
                if (pidx_q < CW'(ssm_pkg::Depth)) begin
                  pidx_d = pidx_q + 1'b1;
                end
              end
            end
            ssm_pkg::OP_READ: begin
              if (CW'(item_i.read_offset) < wl_q) begin
                rd_en = 1'b1;
                raddr = AW'(item_i.read_offset);
                state_d = S_READ;
              end
            end
            ssm_pkg::OP_RUN: begin
              ri_d = cursor_q;
              phase_d = 1'b0;
              state_d = S_RUNRD;
            end
            default: ;
          endcase
        end
      end
      S_SCAN2: begin
        big_d = diff > 64'(ssm_pkg::Depth);
        wl_d = (diff > 64'(ssm_pkg::Depth)) ? '0 : CW'(diff);
        state_d = S_RESP;
      end
      S_BYTE: begin
        we = 1'b1;
        waddr = baddr_q;
        wdata = {conf_new, 1'b1, cur_q.byte_value};
        if (conf_new && !rdata_q[9]) begin
          ccnt_d = ccnt_q + 1'b1;
        end
        if (!rdata_q[8]) begin
          pcnt_d = pcnt_q + 1'b1;
        end
        state_d = S_RESP;
      end
      S_READ: begin
        if (rdata_q[8]) begin
          rdv_d = rdata_q[7:0];
          rdp_d = 1'b1;
        end
        state_d = S_RESP;
      end
      S_RUNRD: begin
        if (ri_q >= wl_q) begin
          cursor_d = ri_q;
          if (phase_q) begin
            rv_d = 1'b1;
            rb_d = lowest_q + 64'(rs_q);
            rl_d = ri_q - rs_q;
          end
          state_d = S_RESP;
        end else begin
          rd_en = 1'b1;
          raddr = ri_q[AW-1:0];
          state_d = S_RUNCK;
        end
      end
      S_RUNCK: begin
        state_d = S_RUNRD;
        if (rdata_q[9]) begin
          if (!phase_q) begin
            rs_d = ri_q;
            phase_d = 1'b1;
          end
          ri_d = ri_q + 1'b1;
        end else if (!phase_q) begin
          ri_d = ri_q + 1'b1;
        end else begin
          // run ends at first unmarked byte
          cursor_d = ri_q;
          rv_d = 1'b1;
          rb_d = lowest_q + 64'(rs_q);
          rl_d = ri_q - rs_q;
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          load = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_CLEAR: begin
        we = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(ssm_pkg::Depth - 1)) begin
          init_d = 1'b0;
          clrcmd_d = 1'b0;
          state_d = clrcmd_q ? S_RESP : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      lowest_q <= '0; highest_q <= '0; any_q <= 1'b0; acnt_q <= '0;
      tmiss_q <= 1'b0; tdiff_q <= 1'b0; ftv_q <= 1'b0; ftime_q <= '0;
      big_q <= 1'b0; wl_q <= '0; base_q <= '0; pidx_q <= '0; pok_q <= 1'b0;
      pcnt_q <= '0; ccnt_q <= '0; cursor_q <= '0;
      clr_q <= '0; init_q <= 1'b1; clrcmd_q <= 1'b0;
      phase_q <= 1'b0; rdp_q <= 1'b0; rv_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lowest_q <= lowest_d; highest_q <= highest_d; any_q <= any_d; acnt_q <= acnt_d;
      tmiss_q <= tmiss_d; tdiff_q <= tdiff_d; ftv_q <= ftv_d; ftime_q <= ftime_d;
      big_q <= big_d; wl_q <= wl_d; base_q <= base_d; pidx_q <= pidx_d; pok_q <= pok_d;
      pcnt_q <= pcnt_d; ccnt_q <= ccnt_d; cursor_q <= cursor_d;
      clr_q <= clr_d; init_q <= init_d; clrcmd_q <= clrcmd_d;
      phase_q <= phase_d; rdp_q <= rdp_d; rv_q <= rv_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    baddr_q <= baddr_d;
    ri_q <= ri_d;
    rs_q <= rs_d;
    rdv_q <= rdv_d;
    rb_q <= rb_d;
    rl_q <= rl_d;
    if (load) begin
      out_q <= res;
    end
  end

endmodule
